/* rtl/core/flbc_pkg.sv */
// Shared constants and types for the multichannel FIR convolver.
package flbc_pkg;
  localparam int unsigned BlockSize = 64;
  localparam int unsigned Channels  = 2;
  localparam int unsigned Taps      = BlockSize + 1;
  localparam int unsigned TapW      = $clog2(Taps + 1);
  localparam int unsigned ChW       = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned SmpW      = 16;
  localparam int unsigned CoefW     = 18;
  localparam int unsigned GainW     = 5;
  localparam int unsigned ProdW     = SmpW + CoefW;
  localparam int unsigned AccW      = ProdW + $clog2(Taps);
  localparam int unsigned ScW       = AccW + GainW;

  localparam logic KindSample = 1'b0;
  localparam logic KindCoef   = 1'b1;

  typedef struct packed {
    logic            rot;   // rotate coef and selected history toward cell 0
    logic            shf;   // shift selected history away from cell 0
    logic [ChW-1:0]  ch;
  } cell_ctl_t;

  typedef struct packed {
    logic prod_en;
    logic acc_clr;
    logic acc_en;
    logic scale_en;
  } mac_ctl_t;
endpackage

/* rtl/core/flbc_cell.sv */
// One tap cell: a kernel word and one history word per channel.
module flbc_cell (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  flbc_pkg::cell_ctl_t                      ctl_i,
  input  logic                                     coef_we_i,
  input  logic signed [flbc_pkg::CoefW-1:0]        coef_wdata_i,
  input  logic signed [flbc_pkg::CoefW-1:0]        nxt_coef_i,
  input  logic signed [flbc_pkg::SmpW-1:0]         nxt_hist_i,
  input  logic signed [flbc_pkg::SmpW-1:0]         prv_hist_i,
  output logic signed [flbc_pkg::CoefW-1:0]        coef_o,
  output logic signed [flbc_pkg::SmpW-1:0]         hist_o
);
  logic signed [flbc_pkg::CoefW-1:0] coef_q;
  logic signed [flbc_pkg::SmpW-1:0]  hist_q [flbc_pkg::Channels];

  always_ff @(posedge clk_i) begin
    if (coef_we_i) begin
      coef_q <= coef_wdata_i;
    end else if (ctl_i.rot) begin
      coef_q <= nxt_coef_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < flbc_pkg::Channels; c++) hist_q[c] <= '0;
    end else if (ctl_i.rot) begin
      hist_q[ctl_i.ch] <= nxt_hist_i;
    end else if (ctl_i.shf) begin
      hist_q[ctl_i.ch] <= prv_hist_i;
    end
  end

  assign coef_o = coef_q;
  assign hist_o = hist_q[ctl_i.ch];
endmodule

/* rtl/core/flbc_mac.sv */
// Multiply-accumulate, gain scaling, rounding and saturation.
module flbc_mac (
  input  logic                                 clk_i,
  input  flbc_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [flbc_pkg::CoefW-1:0]    coef_i,
  input  logic signed [flbc_pkg::SmpW-1:0]     hist_i,
  input  logic [flbc_pkg::GainW-1:0]           gain_i,
  output logic signed [flbc_pkg::SmpW-1:0]     res_o,
  output logic                                 clip_o
);
  localparam int unsigned QW = flbc_pkg::ScW + 1 - 17;

  logic signed [flbc_pkg::ProdW-1:0] prod_q;
  logic signed [flbc_pkg::AccW-1:0]  acc_q;
  logic signed [flbc_pkg::ScW-1:0]   sc_q;
  logic signed [flbc_pkg::ScW:0]     rnd;
  logic signed [QW-1:0]              q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_en) prod_q <= coef_i * hist_i;
    if (ctl_i.acc_en) begin
      acc_q <= (ctl_i.acc_clr ? flbc_pkg::AccW'(0) : acc_q)
               + flbc_pkg::AccW'(prod_q);
    end
    if (ctl_i.scale_en) begin
      sc_q <= flbc_pkg::ScW'(acc_q) * $signed({1'b0, gain_i});
    end
  end

  // half rounds toward plus infinity
  assign rnd = (flbc_pkg::ScW+1)'(sc_q) + (flbc_pkg::ScW+1)'(65536);
  assign q   = rnd[flbc_pkg::ScW:17];

  always_comb begin
    clip_o = 1'b0;
    res_o  = q[flbc_pkg::SmpW-1:0];
    if (q > QW'(32767)) begin
      res_o  = 16'sh7fff;
      clip_o = 1'b1;
    end else if (q < -QW'(32768)) begin
      res_o  = 16'sh8000;
      clip_o = 1'b1;
    end
  end
endmodule

/* rtl/core/fir_lowpass_block_convolver.sv */
// Top level: multichannel FIR convolver built as a rotating row of tap cells.
//
// Input stream: tuser = {channel, kind}; kind 0 is an audio sample, kind 1
// loads kernel word coef_index with coef_value (no result; input stays ready).
// Each audio sample gives one result item on the output stream:
// tdata = filtered, tuser = {clipped, out_channel}.
// A sample item runs these steps in order: the sample is shifted into the
// channel history, the kernel and history row rotates past the single
// multiplier at cell 0 (one tap per step), the accumulate and gain scaling
// steps follow, and a last step rounds, saturates and loads the output
// register. Input is not ready again until the current sample item has
// reached the output register.
// The gain register (cfg_we_i / cfg_wdata_i) resets to 1; write it while idle.
// Reset clears all history to zero; kernel words must be loaded before use.
// When the receiver stalls, the finished result waits in the output
// register; the next item may already be accepted and run, and its result
// waits until the output register is free.
module fir_lowpass_block_convolver (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [flbc_pkg::GainW-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] sample, [22:16] coef_index, [40:23] coef_value, rest zero
  input  logic [47:0]                      s_axis_tdata,
  // [0] kind, [1] channel
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] filtered
  output logic [15:0]                      m_axis_tdata,
  // [0] out_channel, [1] clipped
  output logic [1:0]                       m_axis_tuser
);
  localparam int unsigned Taps = flbc_pkg::Taps;
  localparam int unsigned TapW = flbc_pkg::TapW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [TapW-1:0]                cnt_q, cnt_d;
  logic [flbc_pkg::GainW-1:0]     gain_q;
  logic signed [flbc_pkg::SmpW-1:0] smp_q;
  logic [flbc_pkg::ChW-1:0]       ch_q;
  logic                           ovalid_q;
  logic [15:0]                    odata_q;
  logic [1:0]                     ouser_q;

  logic                           in_acc, kind, coef_ld;
  logic [TapW-1:0]                cidx;
  logic signed [flbc_pkg::CoefW-1:0] cval;
  flbc_pkg::cell_ctl_t            cctl;
  flbc_pkg::mac_ctl_t             mctl;
  logic signed [flbc_pkg::SmpW-1:0] res;
  logic                           clip;

  logic signed [flbc_pkg::CoefW-1:0] coef_w [Taps];
  logic signed [flbc_pkg::SmpW-1:0]  hist_w [Taps];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign kind          = s_axis_tuser[0];
  assign cidx          = s_axis_tdata[22:16];
  assign cval          = s_axis_tdata[40:23];
  assign coef_ld       = in_acc && (kind == flbc_pkg::KindCoef);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= flbc_pkg::GainW'(1);
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q <= s_axis_tdata[15:0];
      ch_q  <= s_axis_tuser[1];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (kind == flbc_pkg::KindSample)) state_d = S_SHIFT;
      end
      S_SHIFT: begin
        state_d = S_RUN;
        cnt_d   = '0;
      end
      S_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == TapW'(Taps - 1)) state_d = S_ACC;
      end
      S_ACC:   state_d = S_SCALE;
      S_SCALE: state_d = S_OUT;
      S_OUT: begin
        if (!ovalid_q || m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_OUT && (!ovalid_q || m_axis_tready)) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!ovalid_q || m_axis_tready)) begin
      odata_q <= res;
      ouser_q <= {clip, ch_q};
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  assign cctl.rot = (state_q == S_RUN);
  assign cctl.shf = (state_q == S_SHIFT);
  assign cctl.ch  = ch_q;

  assign mctl.prod_en  = (state_q == S_RUN);
  assign mctl.acc_en   = (state_q == S_ACC) || (state_q == S_RUN && cnt_q != '0);
  assign mctl.acc_clr  = (state_q == S_RUN && cnt_q == TapW'(1));
  assign mctl.scale_en = (state_q == S_SCALE);

  for (genvar i = 0; i < Taps; i++) begin : g_cell
    localparam int unsigned Nxt = (i == Taps - 1) ? 0 : i + 1;
    logic signed [flbc_pkg::SmpW-1:0] prv;
    if (i == 0) begin : g_head
      assign prv = smp_q;
    end else begin : g_body
      assign prv = hist_w[i-1];
    end
    flbc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cctl),
      .coef_we_i    (coef_ld && (cidx == TapW'(i))),
      .coef_wdata_i (cval),
      .nxt_coef_i   (coef_w[Nxt]),
      .nxt_hist_i   (hist_w[Nxt]),
      .prv_hist_i   (prv),
      .coef_o       (coef_w[i]),
      .hist_o       (hist_w[i])
    );
  end

  flbc_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mctl),
    .coef_i (coef_w[0]),
    .hist_i (hist_w[0]),
    .gain_i (gain_q),
    .res_o  (res),
    .clip_o (clip)
  );

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (cnt_q <= TapW'(Taps - 1)))
    else $error("tap counter out of range");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_OUT))
    else $error("result appeared outside output state");
  a_smp_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind == flbc_pkg::KindSample) |=> (state_q == S_SHIFT))
    else $error("sample item did not start a pass");
`endif
endmodule

/* tb/sv/tb_fir_lowpass_block_convolver.sv */
// Testbench for the multichannel FIR convolver: kernel loads, samples, gain and stalls.
module tb_fir_lowpass_block_convolver;
  localparam int unsigned IdleWait = 80;
  localparam int unsigned StallLimit = 3000;

  typedef struct {
    logic signed [flbc_pkg::SmpW-1:0] filtered;
    logic [flbc_pkg::ChW-1:0]         ch;
    logic                             clipped;
  } fir_out_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [flbc_pkg::GainW-1:0] cfg_wdata_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  // local copy of the filter state
  logic signed [flbc_pkg::CoefW-1:0] kernel_words [flbc_pkg::Taps];
  logic signed [flbc_pkg::SmpW-1:0]  ch_history [flbc_pkg::Channels][flbc_pkg::BlockSize];
  logic [flbc_pkg::GainW-1:0]        gain_reg;

  fir_out_t pending_outputs[$];
  int       mismatches;
  bit       quiet;
  bit       hold_req;
  int       stall_cycles;

  fir_lowpass_block_convolver uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic fir_out_t filter_sample(logic [flbc_pkg::ChW-1:0] ch,
                                             logic signed [flbc_pkg::SmpW-1:0] x);
    fir_out_t res;
    longint   acc;
    longint   r;
    acc = longint'(kernel_words[0]) * longint'(x);
    for (int k = 1; k < flbc_pkg::Taps; k++) begin
      acc += longint'(kernel_words[k]) * longint'(ch_history[ch][k-1]);
    end
    acc *= longint'({1'b0, gain_reg});
    r = (acc + (64'sd1 <<< 16)) >>> 17;   // round half up
    res.clipped = 1'b0;
    if (r > 32767) begin
      r = 32767;
      res.clipped = 1'b1;
    end else if (r < -32768) begin
      r = -32768;
      res.clipped = 1'b1;
    end
    res.filtered = r[15:0];
    res.ch = ch;
    for (int k = flbc_pkg::BlockSize - 1; k > 0; k--) begin
      ch_history[ch][k] = ch_history[ch][k-1];
    end
    ch_history[ch][0] = x;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // offer one item and wait until it is accepted; tvalid stays high afterwards
  task automatic send_item(logic kind, logic [flbc_pkg::ChW-1:0] ch, logic [15:0] smp,
                           logic [6:0] idx, logic [17:0] cval);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, cval, idx, smp};
    s_axis_tuser  <= {ch, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind == flbc_pkg::KindCoef) begin
      if (idx < flbc_pkg::Taps) kernel_words[idx] = cval;
    end else begin
      pending_outputs.push_back(filter_sample(ch, smp));
    end
  endtask

  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [flbc_pkg::GainW-1:0] g);
    drain_outputs();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gain_reg = g;
  endtask

  task automatic send_random_sample();
    send_item(flbc_pkg::KindSample,
              flbc_pkg::ChW'($urandom_range(0, flbc_pkg::Channels - 1)), 16'($urandom),
              7'($urandom), 18'($urandom));
  endtask

  task automatic load_kernel_random();
    for (int k = 0; k < flbc_pkg::Taps; k++) begin
      send_item(flbc_pkg::KindCoef, 1'b0, 16'($urandom), 7'(k),
                18'($urandom_range(0, 8191) - 4096));
    end
  endtask

  task automatic test_directed();
    for (int k = 0; k < flbc_pkg::Taps; k++)
      send_item(flbc_pkg::KindCoef, 1'b1, 16'hffff, 7'(k), 18'd0);
    send_item(flbc_pkg::KindCoef, 1'b0, 16'd0, 7'd0, 18'sd65536);     // half gain on tap 0
    send_item(flbc_pkg::KindSample, 1'b0, 16'sd1, 7'd0, 18'd0);        // exact half rounds up
    send_item(flbc_pkg::KindSample, 1'b1, -16'sd1, 7'd0, 18'd0);       // minus half to zero
    send_item(flbc_pkg::KindCoef, 1'b0, 16'd0, 7'd0, 18'sd131071);
    send_item(flbc_pkg::KindCoef, 1'b0, 16'd0, 7'd65, 18'sd5);         // index past last tap
    send_item(flbc_pkg::KindCoef, 1'b0, 16'd0, 7'd127, 18'h3ffff);
    send_item(flbc_pkg::KindSample, 1'b0, 16'sd32767, 7'd0, 18'd0);
    send_item(flbc_pkg::KindSample, 1'b1, -16'sd32768, 7'd0, 18'd0);
    send_item(flbc_pkg::KindCoef, 1'b0, 16'd0, 7'd64, 18'h20000);      // last tap, most negative
    send_item(flbc_pkg::KindSample, 1'b0, 16'sd0, 7'd0, 18'd0);
    write_gain(5'd16);
    send_item(flbc_pkg::KindSample, 1'b0, 16'sd32767, 7'd0, 18'd0);    // clips high
    send_item(flbc_pkg::KindSample, 1'b1, -16'sd32768, 7'd0, 18'd0);   // clips low
    write_gain(5'd0);
    send_item(flbc_pkg::KindSample, 1'b1, 16'sd12345, 7'd0, 18'd0);
    write_gain(5'd31);
    send_item(flbc_pkg::KindSample, 1'b0, -16'sd2000, 7'd0, 18'd0);
  endtask

  task automatic test_random_phase(logic [flbc_pkg::GainW-1:0] g, int n);
    write_gain(g);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(flbc_pkg::KindCoef, flbc_pkg::ChW'($urandom), 16'($urandom),
                  7'($urandom_range(0, 9) == 0 ? $urandom_range(flbc_pkg::Taps, 127)
                                               : $urandom_range(0, flbc_pkg::Taps - 1)),
                  18'($urandom));
      end else begin
        send_random_sample();
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (20) send_random_sample();
  endtask

  // receiver: random stalls, one long hold-off when asked
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (stall_cycles = 0; stall_cycles < 500; stall_cycles++) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected result", $signed(m_axis_tdata), 0);
      end else begin
        fir_out_t want;
        want = pending_outputs.pop_front();
        if (m_axis_tdata !== want.filtered)
          report_mismatch("filtered", $signed(m_axis_tdata), want.filtered);
        if (m_axis_tuser[0] !== want.ch) report_mismatch("out_channel", m_axis_tuser[0], want.ch);
        if (m_axis_tuser[1] !== want.clipped)
          report_mismatch("clipped", m_axis_tuser[1], want.clipped);
      end
    end
  end

  // watchdog: cycles without any accepted item on either side
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    mismatches = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    gain_reg = 5'd1;
    for (int c = 0; c < flbc_pkg::Channels; c++)
      for (int k = 0; k < flbc_pkg::BlockSize; k++) ch_history[c][k] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_gain(5'd1);
    load_kernel_random();
    test_random_phase(5'd1, 180);
    test_backpressure();
    test_random_phase(5'd16, 160);
    test_random_phase(5'($urandom_range(2, 15)), 160);
    test_random_phase(5'd0, 60);
    test_random_phase(5'd31, 100);
    quiet = 1'b1;
    test_random_phase(5'($urandom_range(1, 16)), 150);
    drain_outputs();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/flbc_pkg.sv
rtl/core/flbc_cell.sv
rtl/core/flbc_mac.sv
rtl/core/fir_lowpass_block_convolver.sv
tb/sv/tb_fir_lowpass_block_convolver.sv
